// ===== hdl/row_cache_bunch_dispenser_assert.svh =====
// Assertion macros shared by the row cache bunch dispenser modules
`ifndef ROW_CACHE_BUNCH_DISPENSER_ASSERT_SVH
`define ROW_CACHE_BUNCH_DISPENSER_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define RCBD_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rcbd assertion failed");

// Next-cycle implication, disabled in reset
`define RCBD_ASSERT_NXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rcbd assertion failed");

`endif

// ===== hdl/rcbd_pkg.sv =====
// Shared types, codes and constants of the row cache bunch dispenser
package rcbd_pkg;

  localparam int CACHE_DEPTH_DEF  = 1024;
  localparam int MAX_BUNCH_DEF    = 64;
  localparam int FEATURE_BITS_DEF = 64;
  localparam int TARGET_BITS_DEF  = 32;

  localparam int CRU_W    = 11;
  localparam int BUNCH_W  = 7;
  localparam int DISC_W   = 32;
  localparam int STATUS_W = 3;

  localparam logic [CRU_W-1:0]   CACHE_ROWS_RESET = 11'd1024;
  localparam logic [BUNCH_W-1:0] BUNCH_ROWS_RESET = 7'd64;

  localparam logic CFG_CACHE_ROWS = 1'b0;
  localparam logic CFG_BUNCH_ROWS = 1'b1;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_BUNCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_CACHED    = 3'd0,
    ST_LEFTOVER  = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_REJECTED  = 3'd3,
    ST_BUNCH     = 3'd4,
    ST_EMPTY_ERR = 3'd5,
    ST_CFG_ERR   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PH_EMPTY   = 2'd0,
    PH_INTAKE  = 2'd1,
    PH_FULL    = 2'd2,
    PH_EXHAUST = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MOVE = 3'b010,
    S_ROWS = 3'b100
  } ctrl_state_t;

  typedef struct packed {
    logic [CRU_W-1:0]   cache_rows;
    logic [BUNCH_W-1:0] bunch_rows;
    logic               ok;
    logic               busy;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic err_cfg;
    logic err_empty;
    logic add_now;
    logic add_held;
    logic empty_start;
    logic move_step;
    logic bunch_start;
    logic bunch_row;
  } cmd_t;

  typedef struct packed {
    logic phase_empty;
    logic move_idle;
    logic row_last;
  } sts_t;

endpackage

// ===== hdl/rcbd_cfg.sv =====
// Configuration registers and serial divisibility check of bunch size
module rcbd_cfg #(
  parameter int CACHE_DEPTH = rcbd_pkg::CACHE_DEPTH_DEF,
  parameter int MAX_BUNCH   = rcbd_pkg::MAX_BUNCH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic                       cfg_index,
  input  logic [rcbd_pkg::CRU_W-1:0] cfg_data,
  output rcbd_pkg::cfg_t             cfg
);

  localparam int CW  = rcbd_pkg::CRU_W;
  localparam int BW  = rcbd_pkg::BUNCH_W;
  localparam int CBW = $clog2(CW);
  localparam logic RESET_DIV_OK =
    ((int'(rcbd_pkg::CACHE_ROWS_RESET) % int'(rcbd_pkg::BUNCH_ROWS_RESET)) == 0);

  logic [CW-1:0]  cache_rows;
  logic [BW-1:0]  bunch_rows;
  logic           div_ok;
  logic           checking;
  logic [CBW-1:0] chk_bit;
  logic [BW-1:0]  rem;
  logic [BW:0]    rem2;
  logic [BW-1:0]  rem_next;

  // one quotient bit per cycle, most significant first
  always_comb begin
    rem2 = {rem, cache_rows[chk_bit]};
    if (rem2 >= {1'b0, bunch_rows}) begin
      rem_next = BW'(rem2 - {1'b0, bunch_rows});
    end else begin
      rem_next = rem2[BW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_rows <= rcbd_pkg::CACHE_ROWS_RESET;
      bunch_rows <= rcbd_pkg::BUNCH_ROWS_RESET;
      div_ok     <= RESET_DIV_OK;
      checking   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rcbd_pkg::CFG_CACHE_ROWS: cache_rows <= cfg_data[CW-1:0];
        rcbd_pkg::CFG_BUNCH_ROWS: bunch_rows <= cfg_data[BW-1:0];
        default: ;
      endcase
      checking <= 1'b1;
    end else if (checking) begin
      if (chk_bit == '0) begin
        checking <= 1'b0;
        div_ok   <= (rem_next == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_write) begin
      chk_bit <= CBW'(CW - 1);
      rem     <= '0;
    end else if (checking) begin
      chk_bit <= chk_bit - 1'b1;
      rem     <= rem_next;
    end
  end

  assign cfg.cache_rows = cache_rows;
  assign cfg.bunch_rows = bunch_rows;
  assign cfg.busy       = checking;
  assign cfg.ok         = div_ok && (bunch_rows != '0) && (int'(bunch_rows) <= MAX_BUNCH)
                          && (cache_rows != '0) && (int'(cache_rows) <= CACHE_DEPTH);

endmodule

// ===== hdl/rcbd_ctrl.sv =====
// Sequencing state machine: decode of items, leftover move and bunch emission
`include "row_cache_bunch_dispenser_assert.svh"

module rcbd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           mode,
  input  rcbd_pkg::cfg_t cfg,
  input  rcbd_pkg::sts_t sts,
  output logic           busy,
  output rcbd_pkg::cmd_t cmd
);

  rcbd_pkg::ctrl_state_t state;
  rcbd_pkg::ctrl_state_t state_next;
  logic                  in_rows;

  assign busy    = (state != rcbd_pkg::S_IDLE) || cfg.busy;
  assign in_rows = (state == rcbd_pkg::S_ROWS);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      rcbd_pkg::S_IDLE: begin
        if (start && !busy) begin
          cmd.capture = 1'b1;
          priority if (!cfg.ok) begin
            cmd.err_cfg = 1'b1;
          end else if (mode == rcbd_pkg::MODE_BUNCH) begin
            if (sts.phase_empty) begin
              cmd.err_empty = 1'b1;
            end else begin
              cmd.bunch_start = 1'b1;
              state_next      = rcbd_pkg::S_ROWS;
            end
          end else if (sts.phase_empty) begin
            cmd.empty_start = 1'b1;
            state_next      = rcbd_pkg::S_MOVE;
          end else begin
            cmd.add_now = 1'b1;
          end
        end
      end
      rcbd_pkg::S_MOVE: begin
        // finish the copy, then store the held row
        if (sts.move_idle) begin
          cmd.add_held = 1'b1;
          state_next   = rcbd_pkg::S_IDLE;
        end else begin
          cmd.move_step = 1'b1;
        end
      end
      rcbd_pkg::S_ROWS: begin
        cmd.bunch_row = 1'b1;
        if (sts.row_last) begin
          state_next = rcbd_pkg::S_IDLE;
        end
      end
      default: state_next = rcbd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcbd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `RCBD_ASSERT_NXT(a_rows_continue, clk, rst, in_rows && !sts.row_last, in_rows)

endmodule

// ===== hdl/rcbd_dp.sv =====
// Datapath: cache and leftover memories, pointers, discard count, result register
`include "row_cache_bunch_dispenser_assert.svh"

module rcbd_dp #(
  parameter int CACHE_DEPTH  = rcbd_pkg::CACHE_DEPTH_DEF,
  parameter int MAX_BUNCH    = rcbd_pkg::MAX_BUNCH_DEF,
  parameter int FEATURE_BITS = rcbd_pkg::FEATURE_BITS_DEF,
  parameter int TARGET_BITS  = rcbd_pkg::TARGET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rcbd_pkg::cfg_t                cfg,
  input  rcbd_pkg::cmd_t                cmd,
  input  logic [FEATURE_BITS-1:0]       feature_word,
  input  logic [TARGET_BITS-1:0]        target_word,
  input  logic                          segment_end,
  output rcbd_pkg::sts_t                sts,
  output logic                          result_strobe,
  output logic [rcbd_pkg::STATUS_W-1:0] status,
  output logic [FEATURE_BITS-1:0]       row_feature,
  output logic [TARGET_BITS-1:0]        row_target,
  output logic                          row_valid,
  output logic                          last_of_run,
  output logic [rcbd_pkg::DISC_W-1:0]   discarded_total
);

  localparam int AW   = $clog2(CACHE_DEPTH);
  localparam int IPW  = $clog2(CACHE_DEPTH + 1);
  localparam int CW   = rcbd_pkg::CRU_W;
  localparam int BW   = rcbd_pkg::BUNCH_W;
  localparam int XW   = ((IPW > CW) ? IPW : CW) + 1;
  localparam int KW   = $clog2(MAX_BUNCH + 1);
  localparam int DW   = FEATURE_BITS + TARGET_BITS;
  localparam int DCW  = rcbd_pkg::DISC_W;

  logic [DW-1:0] cache_mem [CACHE_DEPTH];
  logic [DW-1:0] left_mem  [CACHE_DEPTH];
  logic [DW-1:0] cache_rdata;
  logic [DW-1:0] left_rdata;

  rcbd_pkg::phase_t phase;
  logic [IPW-1:0]   intake;
  logic [IPW-1:0]   exh;
  logic [IPW-1:0]   left_cnt;
  logic [IPW-1:0]   mv_rd;
  logic [IPW-1:0]   b_idx;
  logic [AW-1:0]    mv_waddr;
  logic             mv_pend;
  logic             seg_open;
  logic [DCW-1:0]   disc;
  logic [KW-1:0]    k;

  logic [FEATURE_BITS-1:0] h_feat;
  logic [TARGET_BITS-1:0]  h_targ;
  logic                    h_se;

  rcbd_pkg::status_t o_status;
  logic              o_valid;
  logic              o_last;

  logic [FEATURE_BITS-1:0] a_feat;
  logic [TARGET_BITS-1:0]  a_targ;
  logic                    a_se;
  logic                    do_add;
  logic                    emit;
  logic                    in_room;
  logic                    left_room;
  logic [IPW-1:0]          intake_inc;
  rcbd_pkg::status_t       add_status;
  logic [XW-1:0]           x_intake;
  logic [XW-1:0]           x_cru;
  logic [XW-1:0]           x_bunch;
  logic [XW-1:0]           x_left;
  logic [XW-1:0]           x_exh;
  logic [IPW-1:0]          bunch_p;
  logic [IPW-1:0]          move_n;
  logic [IPW-1:0]          eff_exh;
  logic [IPW-1:0]          end_val;
  logic                    fin;
  logic [IPW-1:0]          gap;
  logic [DCW:0]            disc_sum;
  logic [DCW-1:0]          disc_sat;
  logic                    k_last;
  logic                    mv_write;
  logic                    mv_read;
  logic                    cache_we;
  logic [AW-1:0]           cache_waddr;
  logic [DW-1:0]           cache_wdata;
  logic                    left_we;

  assign x_intake = XW'(intake);
  assign x_cru    = XW'(cfg.cache_rows);
  assign x_bunch  = XW'(cfg.bunch_rows);
  assign x_left   = XW'(left_cnt);
  assign x_exh    = XW'(exh);
  assign bunch_p  = IPW'(x_bunch);

  // row source: ports on the accept cycle, held copy after a leftover move
  assign a_feat = cmd.add_held ? h_feat : feature_word;
  assign a_targ = cmd.add_held ? h_targ : target_word;
  assign a_se   = cmd.add_held ? h_se   : segment_end;
  assign do_add = cmd.add_now | cmd.add_held;
  assign emit   = cmd.err_cfg | cmd.err_empty | do_add | cmd.bunch_row;

  assign in_room    = (phase == rcbd_pkg::PH_INTAKE) && (x_intake < x_cru);
  assign left_room  = x_left < XW'(CACHE_DEPTH);
  assign intake_inc = intake + 1'b1;

  always_comb begin
    priority if (in_room) begin
      add_status = rcbd_pkg::ST_CACHED;
    end else if (!seg_open) begin
      add_status = rcbd_pkg::ST_REJECTED;
    end else if (left_room) begin
      add_status = rcbd_pkg::ST_LEFTOVER;
    end else begin
      add_status = rcbd_pkg::ST_DROPPED;
    end
  end

  // rows moved out of the leftover store, capped at the cache size
  assign move_n = (x_left > x_cru) ? IPW'(x_cru) : left_cnt;

  assign eff_exh  = (phase == rcbd_pkg::PH_EXHAUST) ? exh : '0;
  assign end_val  = eff_exh + bunch_p;
  assign fin      = (x_exh + x_bunch) > x_intake;
  assign gap      = intake - exh;
  assign disc_sum = {1'b0, disc} + (DCW + 1)'(gap);
  assign disc_sat = disc_sum[DCW] ? '1 : disc_sum[DCW-1:0];
  assign k_last   = (BW'(k) == (cfg.bunch_rows - 1'b1));

  assign mv_write    = cmd.move_step && mv_pend;
  assign mv_read     = cmd.move_step && (mv_rd < intake);
  assign cache_we    = mv_write || (do_add && in_room);
  assign cache_waddr = mv_write ? mv_waddr : intake[AW-1:0];
  assign cache_wdata = mv_write ? left_rdata : {a_feat, a_targ};
  assign left_we     = do_add && !in_room && seg_open && left_room;

  always_ff @(posedge clk) begin
    if (cache_we) begin
      cache_mem[cache_waddr] <= cache_wdata;
    end
    if (cmd.bunch_row) begin
      cache_rdata <= cache_mem[b_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (left_we) begin
      left_mem[left_cnt[AW-1:0]] <= {a_feat, a_targ};
    end
    if (mv_read) begin
      left_rdata <= left_mem[mv_rd[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= rcbd_pkg::PH_EMPTY;
      intake        <= '0;
      exh           <= '0;
      left_cnt      <= '0;
      mv_rd         <= '0;
      mv_pend       <= 1'b0;
      b_idx         <= '0;
      k             <= '0;
      seg_open      <= 1'b0;
      disc          <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit;
      if (cmd.empty_start) begin
        intake   <= move_n;
        left_cnt <= '0;
        phase    <= rcbd_pkg::PH_INTAKE;
        mv_rd    <= '0;
        mv_pend  <= 1'b0;
      end
      if (cmd.move_step) begin
        if (mv_rd < intake) begin
          mv_rd   <= mv_rd + 1'b1;
          mv_pend <= 1'b1;
        end else begin
          mv_pend <= 1'b0;
        end
      end
      if (do_add) begin
        if (in_room) begin
          intake   <= intake_inc;
          phase    <= (XW'(intake_inc) >= x_cru) ? rcbd_pkg::PH_FULL : rcbd_pkg::PH_INTAKE;
          seg_open <= !a_se;
        end else begin
          if (phase == rcbd_pkg::PH_INTAKE) begin
            phase <= rcbd_pkg::PH_FULL;
          end
          if (seg_open) begin
            if (left_room) begin
              left_cnt <= left_cnt + 1'b1;
            end
            seg_open <= !a_se;
          end
        end
      end
      if (cmd.bunch_start) begin
        b_idx <= eff_exh;
        exh   <= end_val;
        k     <= '0;
        phase <= rcbd_pkg::PH_EXHAUST;
      end
      if (cmd.bunch_row) begin
        b_idx <= b_idx + 1'b1;
        k     <= k + 1'b1;
        // no full bunch left after this one: count unread rows, go empty
        if ((k == '0) && fin) begin
          if (x_intake > x_exh) begin
            disc <= disc_sat;
          end
          phase <= rcbd_pkg::PH_EMPTY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      h_feat <= feature_word;
      h_targ <= target_word;
      h_se   <= segment_end;
    end
    if (mv_read) begin
      mv_waddr <= mv_rd[AW-1:0];
    end
    if (emit) begin
      priority if (cmd.err_cfg) begin
        o_status <= rcbd_pkg::ST_CFG_ERR;
      end else if (cmd.err_empty) begin
        o_status <= rcbd_pkg::ST_EMPTY_ERR;
      end else if (do_add) begin
        o_status <= add_status;
      end else begin
        o_status <= rcbd_pkg::ST_BUNCH;
      end
      o_valid <= cmd.bunch_row && (b_idx < intake);
      o_last  <= cmd.bunch_row ? k_last : 1'b1;
    end
  end

  assign status          = o_status;
  assign row_valid       = o_valid;
  assign last_of_run     = o_last;
  assign row_feature     = o_valid ? cache_rdata[DW-1:TARGET_BITS] : '0;
  assign row_target      = o_valid ? cache_rdata[TARGET_BITS-1:0] : '0;
  assign discarded_total = disc;

  assign sts.phase_empty = (phase == rcbd_pkg::PH_EMPTY);
  assign sts.move_idle   = (mv_rd == intake) && !mv_pend;
  assign sts.row_last    = k_last;

  `RCBD_ASSERT_IMP(a_valid_only_bunch, clk, rst, result_strobe && o_valid, o_status == rcbd_pkg::ST_BUNCH)
  `RCBD_ASSERT_IMP(a_held_add_after_move, clk, rst, cmd.add_held, !mv_pend && (mv_rd == intake))

endmodule

// ===== hdl/row_cache_bunch_dispenser.sv =====
// Row add: result in the cycle after the start transfer; next start accepted the following cycle.
// Row add while the cache is empty: n leftover rows are copied first, one per cycle through
//   the leftover memory read port; the held row is then stored and its result given.
// Bunch request of b rows: the b rows go out back to back, one cache read per row.
// Config write: serial divisibility check (busy high). Reset clears control state only; the
//   memories keep contents; reads past the held rows give zeroed rows with row_valid low.
module row_cache_bunch_dispenser #(
  parameter int CACHE_DEPTH  = rcbd_pkg::CACHE_DEPTH_DEF,
  parameter int MAX_BUNCH    = rcbd_pkg::MAX_BUNCH_DEF,
  parameter int FEATURE_BITS = rcbd_pkg::FEATURE_BITS_DEF,
  parameter int TARGET_BITS  = rcbd_pkg::TARGET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode,
  input  logic [FEATURE_BITS-1:0]       feature_word,
  input  logic [TARGET_BITS-1:0]        target_word,
  input  logic                          segment_end,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [rcbd_pkg::CRU_W-1:0]    cfg_data,
  output logic                          result_strobe,
  output logic [rcbd_pkg::STATUS_W-1:0] status,
  output logic [FEATURE_BITS-1:0]       row_feature,
  output logic [TARGET_BITS-1:0]        row_target,
  output logic                          row_valid,
  output logic                          last_of_run,
  output logic [rcbd_pkg::DISC_W-1:0]   discarded_total
);

  rcbd_pkg::cfg_t cfg;
  rcbd_pkg::cmd_t cmd;
  rcbd_pkg::sts_t sts;

  rcbd_cfg #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .MAX_BUNCH   (MAX_BUNCH)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rcbd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .cfg   (cfg),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  rcbd_dp #(
    .CACHE_DEPTH  (CACHE_DEPTH),
    .MAX_BUNCH    (MAX_BUNCH),
    .FEATURE_BITS (FEATURE_BITS),
    .TARGET_BITS  (TARGET_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .feature_word    (feature_word),
    .target_word     (target_word),
    .segment_end     (segment_end),
    .sts             (sts),
    .result_strobe   (result_strobe),
    .status          (status),
    .row_feature     (row_feature),
    .row_target      (row_target),
    .row_valid       (row_valid),
    .last_of_run     (last_of_run),
    .discarded_total (discarded_total)
  );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the row cache bunch dispenser: directed and random traffic
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = rcbd_pkg::CACHE_DEPTH_DEF;
  localparam int BMAX  = rcbd_pkg::MAX_BUNCH_DEF;
  localparam int FW    = rcbd_pkg::FEATURE_BITS_DEF;
  localparam int TW    = rcbd_pkg::TARGET_BITS_DEF;

  typedef struct {
    logic          mode;
    logic [FW-1:0] feat;
    logic [TW-1:0] targ;
    logic          seg_end;
  } row_cmd_t;

  typedef struct {
    rcbd_pkg::status_t           status;
    logic [FW-1:0]               feat;
    logic [TW-1:0]               targ;
    logic                        valid;
    logic                        last;
    logic [rcbd_pkg::DISC_W-1:0] disc;
  } dispensed_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          mode = rcbd_pkg::MODE_ADD;
  logic [FW-1:0]                 feature_word = '0;
  logic [TW-1:0]                 target_word = '0;
  logic                          segment_end = 1'b0;
  logic                          cfg_write = 1'b0;
  logic                          cfg_index = rcbd_pkg::CFG_CACHE_ROWS;
  logic [rcbd_pkg::CRU_W-1:0]    cfg_data = '0;
  logic                          result_strobe;
  logic [rcbd_pkg::STATUS_W-1:0] status;
  logic [FW-1:0]                 row_feature;
  logic [TW-1:0]                 row_target;
  logic                          row_valid;
  logic                          last_of_run;
  logic [rcbd_pkg::DISC_W-1:0]   discarded_total;

  row_cache_bunch_dispenser dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .feature_word   (feature_word),
    .target_word    (target_word),
    .segment_end    (segment_end),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .result_strobe  (result_strobe),
    .status         (status),
    .row_feature    (row_feature),
    .row_target     (row_target),
    .row_valid      (row_valid),
    .last_of_run    (last_of_run),
    .discarded_total(discarded_total)
  );

  // Shadow state of the dispenser
  bit [FW-1:0]                 cache_feat [DEPTH];
  bit [TW-1:0]                 cache_targ [DEPTH];
  bit [FW-1:0]                 spill_feat [DEPTH];
  bit [TW-1:0]                 spill_targ [DEPTH];
  rcbd_pkg::phase_t            m_phase = rcbd_pkg::PH_EMPTY;
  int                          m_intake = 0;
  int                          m_exhaust = 0;
  int                          m_spill_cnt = 0;
  logic                        m_seg_open = 1'b0;
  logic [rcbd_pkg::DISC_W-1:0] m_discards = '0;
  int                          m_cache_rows = int'(rcbd_pkg::CACHE_ROWS_RESET);
  int                          m_bunch_rows = int'(rcbd_pkg::BUNCH_ROWS_RESET);

  dispensed_t awaited_rows [$];
  int         failures = 0;
  int         results_seen = 0;
  int         cmds_sent = 0;
  int         cfg_writes = 0;
  int         status_hits [8];
  bit         gaps_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Run timed out with %0d results still pending", awaited_rows.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit shape_ok();
    return !(m_bunch_rows == 0 || m_bunch_rows > BMAX || m_cache_rows == 0 ||
             m_cache_rows > DEPTH || (m_cache_rows % m_bunch_rows) != 0);
  endfunction

  function automatic void queue_result(rcbd_pkg::status_t st, logic [FW-1:0] f,
                                       logic [TW-1:0] t, logic v, logic last);
    dispensed_t r;
    r.status = st;
    r.feat   = f;
    r.targ   = t;
    r.valid  = v;
    r.last   = last;
    r.disc   = m_discards;
    awaited_rows.push_back(r);
  endfunction

  // Work out the results of one accepted command and advance the shadow state
  function automatic void forecast_dispense(row_cmd_t c);
    int                n;
    int                i;
    int                fin;
    int                idx;
    longint            gain;
    rcbd_pkg::status_t st;
    logic              v;
    if (!shape_ok()) begin
      queue_result(rcbd_pkg::ST_CFG_ERR, '0, '0, 1'b0, 1'b1);
      return;
    end
    if (c.mode == rcbd_pkg::MODE_ADD) begin
      if (m_phase == rcbd_pkg::PH_EMPTY) begin
        // refill from the leftover store; rows past the cache size are lost
        n = (m_spill_cnt > m_cache_rows) ? m_cache_rows : m_spill_cnt;
        for (i = 0; i < n; i++) begin
          cache_feat[i] = spill_feat[i];
          cache_targ[i] = spill_targ[i];
        end
        m_spill_cnt = 0;
        m_intake    = n;
        m_phase     = rcbd_pkg::PH_INTAKE;
      end
      if (m_phase == rcbd_pkg::PH_INTAKE && m_intake >= m_cache_rows)
        m_phase = rcbd_pkg::PH_FULL;
      if (m_phase == rcbd_pkg::PH_INTAKE) begin
        cache_feat[m_intake] = c.feat;
        cache_targ[m_intake] = c.targ;
        m_intake++;
        if (m_intake >= m_cache_rows) m_phase = rcbd_pkg::PH_FULL;
        st = rcbd_pkg::ST_CACHED;
        m_seg_open = !c.seg_end;
      end else if (m_seg_open) begin
        if (m_spill_cnt < DEPTH) begin
          spill_feat[m_spill_cnt] = c.feat;
          spill_targ[m_spill_cnt] = c.targ;
          m_spill_cnt++;
          st = rcbd_pkg::ST_LEFTOVER;
        end else begin
          st = rcbd_pkg::ST_DROPPED;
        end
        m_seg_open = !c.seg_end;
      end else begin
        st = rcbd_pkg::ST_REJECTED;
      end
      queue_result(st, '0, '0, 1'b0, 1'b1);
      return;
    end
    if (m_phase == rcbd_pkg::PH_EMPTY) begin
      queue_result(rcbd_pkg::ST_EMPTY_ERR, '0, '0, 1'b0, 1'b1);
      return;
    end
    if (m_phase != rcbd_pkg::PH_EXHAUST) begin
      m_phase   = rcbd_pkg::PH_EXHAUST;
      m_exhaust = 0;
    end
    fin = m_exhaust + m_bunch_rows;
    if (fin + m_bunch_rows > m_intake) begin
      if (m_intake > fin) begin
        gain = longint'(m_discards) + longint'(m_intake - fin);
        m_discards = (gain > 64'hFFFF_FFFF) ? '1 : gain[rcbd_pkg::DISC_W-1:0];
      end
      m_phase = rcbd_pkg::PH_EMPTY;
    end
    for (i = 0; i < m_bunch_rows; i++) begin
      idx = m_exhaust + i;
      v   = idx < m_intake;
      queue_result(rcbd_pkg::ST_BUNCH, v ? cache_feat[idx] : '0,
                   v ? cache_targ[idx] : '0, v, i == m_bunch_rows - 1);
    end
    m_exhaust = fin;
  endfunction

  function automatic void flag_mismatch(string what);
    failures++;
    if (failures <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
  endfunction

  // Check every result transfer against the oldest pending prediction
  always @(posedge clk) begin
    dispensed_t w;
    if (!rst && result_strobe) begin
      results_seen++;
      if (awaited_rows.size() == 0) begin
        flag_mismatch($sformatf("unexpected result st=%0d f=%h t=%h v=%b l=%b d=%0d",
                                status, row_feature, row_target, row_valid, last_of_run,
                                discarded_total));
      end else begin
        w = awaited_rows.pop_front();
        status_hits[w.status]++;
        if (status !== w.status || row_feature !== w.feat || row_target !== w.targ ||
            row_valid !== w.valid || last_of_run !== w.last || discarded_total !== w.disc)
          flag_mismatch($sformatf({"expected st=%0d f=%h t=%h v=%b l=%b d=%0d, ",
                                   "got st=%0d f=%h t=%h v=%b l=%b d=%0d"},
                                  w.status, w.feat, w.targ, w.valid, w.last, w.disc,
                                  status, row_feature, row_target, row_valid, last_of_run,
                                  discarded_total));
      end
    end
  end

  // Hold start until the transfer, then maybe idle a burst
  task automatic send_cmd(row_cmd_t c);
    start        <= 1'b1;
    mode         <= c.mode;
    feature_word <= c.feat;
    target_word  <= c.targ;
    segment_end  <= c.seg_end;
    @(posedge clk);
    while (busy) @(posedge clk);
    forecast_dispense(c);
    cmds_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic add_row(logic seg_end, logic [FW-1:0] f, logic [TW-1:0] t);
    row_cmd_t c;
    c.mode    = rcbd_pkg::MODE_ADD;
    c.feat    = f;
    c.targ    = t;
    c.seg_end = seg_end;
    send_cmd(c);
  endtask

  task automatic add_rand(logic seg_end);
    add_row(seg_end, {$urandom, $urandom}, $urandom);
  endtask

  task automatic ask_bunch();
    row_cmd_t c;
    c.mode    = rcbd_pkg::MODE_BUNCH;
    c.feat    = {$urandom, $urandom};
    c.targ    = $urandom;
    c.seg_end = 1'($urandom_range(0, 1));
    send_cmd(c);
  endtask

  // Request bunches until the cache has been emptied, while the shape is valid
  task automatic run_dry();
    while (shape_ok() && m_phase != rcbd_pkg::PH_EMPTY) ask_bunch();
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_rows.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[rcbd_pkg::CRU_W-1:0];
    @(posedge clk);
    if (idx == rcbd_pkg::CFG_CACHE_ROWS) m_cache_rows = int'(value & 32'h7FF);
    else m_bunch_rows = int'(value & 32'h7F);
    cfg_write <= 1'b0;
    cfg_writes++;
    // wait out the shape check
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_shape(int unsigned cache_rows, int unsigned bunch);
    wait_drained();
    write_reg(rcbd_pkg::CFG_CACHE_ROWS, cache_rows);
    write_reg(rcbd_pkg::CFG_BUNCH_ROWS, bunch);
  endtask

  task automatic try_bad_reg(logic idx, int unsigned value);
    wait_drained();
    write_reg(idx, value);
    add_rand(1'b1);
    ask_bunch();
  endtask

  // Reset shape, then a small one: empty request, payload extremes, partial bunch, discard count
  task automatic test_empty_and_bunches();
    ask_bunch();
    add_row(1'b0, '1, '1);
    add_row(1'b1, '0, '0);
    add_row(1'b0, {FW/4{4'hA}}, {TW/4{4'h5}});
    add_row(1'b1, {FW/4{4'h5}}, {TW/4{4'hA}});
    ask_bunch();
    ask_bunch();
    set_shape(8, 2);
    repeat (7) add_rand(1'b1);
    ask_bunch();
    ask_bunch();
    ask_bunch();
  endtask

  // Each bad shape answers every command with a config error
  task automatic test_register_errors();
    set_shape(10, 3);
    add_rand(1'b0);
    ask_bunch();
    try_bad_reg(rcbd_pkg::CFG_BUNCH_ROWS, 0);
    try_bad_reg(rcbd_pkg::CFG_BUNCH_ROWS, BMAX + 1);
    try_bad_reg(rcbd_pkg::CFG_BUNCH_ROWS, 127);
    wait_drained();
    write_reg(rcbd_pkg::CFG_BUNCH_ROWS, 2);
    try_bad_reg(rcbd_pkg::CFG_CACHE_ROWS, 0);
    try_bad_reg(rcbd_pkg::CFG_CACHE_ROWS, DEPTH + 1);
    try_bad_reg(rcbd_pkg::CFG_CACHE_ROWS, 2047);
  endtask

  // Leftover, rejection, refill and shrinking the cache under rows already held
  task automatic test_segment_rules();
    set_shape(4, 2);
    run_dry();
    repeat (4) add_rand(1'b0);
    add_rand(1'b0);
    add_rand(1'b1);
    add_rand(1'b0);
    ask_bunch();
    add_rand(1'b1);
    ask_bunch();
    ask_bunch();
    add_rand(1'b0);
    set_shape(2, 1);
    add_rand(1'b0);
    add_rand(1'b0);
    add_rand(1'b1);
    run_dry();
    add_rand(1'b1);
    ask_bunch();
    run_dry();
  endtask

  // Spill more rows than a small cache holds, then refill it from the leftover store
  task automatic test_deep_stores();
    set_shape(2, 1);
    run_dry();
    add_rand(1'b0);
    add_rand(1'b0);
    repeat (5) add_rand(1'b0);
    add_rand(1'b1);
    add_rand(1'b0);
    ask_bunch();
    ask_bunch();
    add_rand(1'b1);
    run_dry();
  endtask

  task automatic test_random_traffic();
    int p;
    int b;
    int pick;
    for (p = 0; p < 9; p++) begin
      if (p == 8) gaps_on = 1'b0;
      pick = $urandom_range(0, 9);
      case ($urandom_range(0, 5))
        0: b = 1;
        1: b = 2;
        2: b = 3;
        3: b = 4;
        4: b = 8;
        default: b = BMAX;
      endcase
      if (pick == 0 && p != 8) begin
        set_shape($urandom_range(0, 2047), $urandom_range(0, 127));
      end else if (pick == 1 && m_bunch_rows >= 1 && m_bunch_rows <= BMAX) begin
        // resize the cache under whatever it holds
        wait_drained();
        write_reg(rcbd_pkg::CFG_CACHE_ROWS, m_bunch_rows * $urandom_range(1, 8));
      end else begin
        set_shape(b * $urandom_range(1, 8), b);
      end
      repeat (15) begin
        if (gaps_on && $urandom_range(0, 19) == 0) wait_drained();
        if ($urandom_range(0, 3) == 0) ask_bunch();
        else add_rand($urandom_range(0, 3) == 0);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_bunches();
    test_register_errors();
    test_segment_rules();
    test_deep_stores();
    test_random_traffic();
    wait_drained();
    repeat (BMAX + 8) @(posedge clk);
    $display("Sent %0d commands across %0d register writes; checked %0d results.",
             cmds_sent, cfg_writes, results_seen);
    $display({"Outcomes: cached %0d, leftover %0d, dropped %0d, rejected %0d, ",
              "bunch rows %0d, empty %0d, bad shape %0d; discards %0d"},
             status_hits[rcbd_pkg::ST_CACHED], status_hits[rcbd_pkg::ST_LEFTOVER],
             status_hits[rcbd_pkg::ST_DROPPED], status_hits[rcbd_pkg::ST_REJECTED],
             status_hits[rcbd_pkg::ST_BUNCH], status_hits[rcbd_pkg::ST_EMPTY_ERR],
             status_hits[rcbd_pkg::ST_CFG_ERR], m_discards);
    if (awaited_rows.size() != 0)
      $display("%0d predicted results never arrived", awaited_rows.size());
    if (failures == 0 && awaited_rows.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
